// ----- design/dcw_pkg.sv -----
package dcw_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_WATCH   = 2'd2,
    CMD_UNWATCH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  slot;
    logic [7:0]  data_byte;
    logic        asset_present;
    logic [15:0] delta_ms;
  } dcw_in_t;

  typedef struct packed {
    logic [3:0] out_slot;
    logic       changed;
  } dcw_out_t;

  localparam logic [63:0] FNV_BASIS      = 64'hcbf2_9ce4_8422_2325;
  localparam logic [19:0] DEBOUNCE_RESET = 20'd250;

endpackage

// ----- design/debounced_content_change_watch.sv -----
// Channel   | Direction | Handshake          | Carries
// in        | input     | in_valid/in_stall  | in_request: cmd, slot, byte, present, delta
// out       | output    | out_valid/out_stall| out_request: out_slot, changed
// cfg       | input     | cfg_valid/cfg_ready| cfg_data: debounce_ms
//
// One request per cycle is accepted while in_stall is low; only watched polls on slots below SLOTS set out_valid.
// Each request is worked combinationally between the input and result registers.
// Synchronous reset clears the slot flags at once; no clearing pass is needed.
// A stalled full result register holds the input register, which then raises in_stall.
module debounced_content_change_watch #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcw_pkg::dcw_in_t  in_request,
  output logic              out_valid,
  input  logic              out_stall,
  output dcw_pkg::dcw_out_t out_request,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [19:0]       cfg_data
);
  import dcw_pkg::*;

  logic        q_valid;
  dcw_in_t     q;
  logic        advance;
  logic        go;
  logic [63:0] hash;
  logic [19:0] debounce;
  logic        emit;
  dcw_out_t    res;

  assign advance   = !out_valid || !out_stall;
  assign go        = q_valid && advance;
  assign in_stall  = q_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      q <= in_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_data != 20'd0)) begin
      debounce <= cfg_data;
    end
  end

  dcw_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .step      (go && (q.cmd == CMD_BYTE)),
    .close     (go && ((q.cmd == CMD_POLL) || (q.cmd == CMD_WATCH))),
    .data_byte (q.data_byte),
    .hash      (hash)
  );

  dcw_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .req      (q),
    .hash     (hash),
    .debounce (debounce),
    .emit     (emit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_request <= res;
    end
  end

  a_zero_cfg_kept: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_data == 20'd0) |=> $stable(debounce))
    else $error("zero debounce write changed the register");

endmodule

// ----- design/dcw_hash.sv -----
module dcw_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        close,
  input  logic [7:0]  data_byte,
  output logic [63:0] hash
);
  import dcw_pkg::*;

  logic [63:0] mixed;
  logic [63:0] hash_next;

  // The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  always_comb begin
    mixed     = hash ^ {56'd0, data_byte};
    hash_next = hash;
    if (close) begin
      hash_next = FNV_BASIS;
    end else if (step) begin
      hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                + (mixed << 4) + (mixed << 1) + mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FNV_BASIS;
    end else begin
      hash <= hash_next;
    end
  end

  a_close_basis: assert property (@(posedge clk) disable iff (rst)
    close |=> hash == FNV_BASIS)
    else $error("running hash did not return to the offset basis");

endmodule

// ----- design/dcw_slot_table.sv -----
module dcw_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  dcw_pkg::dcw_in_t req,
  input  logic [63:0]      hash,
  input  logic [19:0]      debounce,
  output logic             emit,
  output dcw_pkg::dcw_out_t res
);
  import dcw_pkg::*;

  localparam int DEPTH = (SLOTS < 16) ? SLOTS : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        watched     [DEPTH];
  logic        pend_flag   [DEPTH];
  logic [63:0] stable_val  [DEPTH];
  logic        stable_pres [DEPTH];
  logic [63:0] pend_val    [DEPTH];
  logic        pend_pres   [DEPTH];
  logic [31:0] elapsed     [DEPTH];

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             wr;
  logic [63:0]      fp;
  logic             cur_w;
  logic             cur_pf;
  logic [63:0]      cur_sv;
  logic             cur_sp;
  logic [63:0]      cur_pv;
  logic             cur_pp;
  logic [31:0]      cur_el;
  logic             match_stable;
  logic             match_pend;
  logic [32:0]      sum;
  logic [31:0]      sat;
  logic             confirm;
  logic             hit;
  logic             changed;
  logic             watched_next;
  logic             pend_flag_next;
  logic [63:0]      stable_val_next;
  logic             stable_pres_next;
  logic [63:0]      pend_val_next;
  logic             pend_pres_next;
  logic [31:0]      elapsed_next;

  always_comb begin
    idx      = req.slot[IDX_W-1:0];
    in_range = {5'd0, req.slot} < 9'(SLOTS);
    wr       = go && in_range && (req.cmd != CMD_BYTE);
    fp       = req.asset_present ? hash : 64'd0;

    cur_w  = watched[idx];
    cur_pf = pend_flag[idx];
    cur_sv = stable_val[idx];
    cur_sp = stable_pres[idx];
    cur_pv = pend_val[idx];
    cur_pp = pend_pres[idx];
    cur_el = elapsed[idx];

    match_stable = (req.asset_present == cur_sp) && (fp == cur_sv);
    match_pend   = cur_pf && (fp == cur_pv) && (req.asset_present == cur_pp);
    sum          = {1'b0, cur_el} + {17'd0, req.delta_ms};
    sat          = sum[32] ? 32'hffff_ffff : sum[31:0];
    confirm      = sat >= {12'd0, debounce};
  end

  always_comb begin
    watched_next     = cur_w;
    pend_flag_next   = cur_pf;
    stable_val_next  = cur_sv;
    stable_pres_next = cur_sp;
    pend_val_next    = cur_pv;
    pend_pres_next   = cur_pp;
    elapsed_next     = cur_el;
    hit              = 1'b0;
    changed          = 1'b0;
    case (req.cmd)
      CMD_WATCH: begin
        watched_next     = 1'b1;
        stable_val_next  = fp;
        stable_pres_next = req.asset_present;
        pend_val_next    = fp;
        pend_pres_next   = req.asset_present;
        pend_flag_next   = 1'b0;
        elapsed_next     = 32'd0;
      end
      CMD_UNWATCH: begin
        watched_next     = 1'b0;
        stable_val_next  = 64'd0;
        stable_pres_next = 1'b0;
        pend_val_next    = 64'd0;
        pend_pres_next   = 1'b0;
        pend_flag_next   = 1'b0;
        elapsed_next     = 32'd0;
      end
      CMD_POLL: begin
        if (cur_w) begin
          hit = 1'b1;
          if (match_stable) begin
            pend_flag_next = 1'b0;
            elapsed_next   = 32'd0;
          end else if (!match_pend) begin
            pend_val_next  = fp;
            pend_pres_next = req.asset_present;
            pend_flag_next = 1'b1;
            elapsed_next   = 32'd0;
          end else if (confirm) begin
            stable_val_next  = cur_pv;
            stable_pres_next = cur_pp;
            pend_flag_next   = 1'b0;
            elapsed_next     = 32'd0;
            changed          = 1'b1;
          end else begin
            elapsed_next = sat;
          end
        end
      end
      default: begin
      end
    endcase

    emit         = go && in_range && hit;
    res.out_slot = req.slot;
    res.changed  = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        watched[i]   <= 1'b0;
        pend_flag[i] <= 1'b0;
      end
    end else if (wr) begin
      watched[idx]   <= watched_next;
      pend_flag[idx] <= pend_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      stable_val[idx]  <= stable_val_next;
      stable_pres[idx] <= stable_pres_next;
      pend_val[idx]    <= pend_val_next;
      pend_pres[idx]   <= pend_pres_next;
      elapsed[idx]     <= elapsed_next;
    end
  end

  a_emit_poll: assert property (@(posedge clk) disable iff (rst)
    emit |-> (req.cmd == CMD_POLL) && in_range && cur_w)
    else $error("result raised for something other than a watched poll");

  a_changed_pending: assert property (@(posedge clk) disable iff (rst)
    emit && changed |-> match_pend && !match_stable)
    else $error("change confirmed without a matching pending value");

  a_watch_sets: assert property (@(posedge clk) disable iff (rst)
    wr && (req.cmd == CMD_WATCH) |=> watched[$past(idx)] && !pend_flag[$past(idx)])
    else $error("watch did not arm the slot");

endmodule
